// ===== rtl/vdd_pkg.sv =====
// ----------------------------------------------------------------------------
// vdd_pkg
// Shared types, constants and helpers for the varint descriptor decoder.
// ----------------------------------------------------------------------------
package vdd_pkg;

  localparam int STREAM_COUNT_DEF    = 256;
  localparam int MAX_FRAME_BYTES_DEF = 2048;
  localparam int TRAILER_BYTES_DEF   = 8;

  localparam int REGION_W = 49;
  localparam logic [REGION_W-1:0] REGION_RESET = 49'h0_0000_8000_0000;

  // wide enough for any frame length, position or trailer sum
  localparam int CMP_W = 14;

  localparam logic [6:0] SHIFT_LIMIT = 7'd63;
  localparam logic [6:0] SHIFT_STEP  = 7'd7;

  typedef enum logic [3:0] {
    PH_SID   = 4'b0001,
    PH_DELTA = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_t;

  localparam logic KIND_DESC   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_NOID  = 2'd2;

endpackage

// ===== rtl/vdd_ram.sv =====
// ----------------------------------------------------------------------------
// vdd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vdd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/varint_delta_descriptor_decoder.sv =====
// ----------------------------------------------------------------------------
// varint_delta_descriptor_decoder
// Byte-serial LEB128 / zigzag delta descriptor decoder with per-stream
// offset memory.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid/in_stall, data_byte,             | in
//           | first_of_frame, frame_length              |
//  result   | out_valid/out_stall, result_kind ... last | out
//  config   | cfg_valid/cfg_ready, region_size          | in
//
// One byte per cycle unless in_stall is high. A byte is parsed in the first
// stage (varint shift/or, stream table read issued); the second stage does
// the 64-bit offset add and range compare and loads the result register, so
// a result is offered once its byte has passed the stage registers and the
// result register. The 256 x 64 offset table is a RAM with reset valid bits,
// so no clearing pass is needed after reset. A stalled result holds a result
// waiting in the second stage, which then stalls the input.
// ----------------------------------------------------------------------------
module varint_delta_descriptor_decoder #(
  parameter int STREAM_COUNT    = vdd_pkg::STREAM_COUNT_DEF,
  parameter int MAX_FRAME_BYTES = vdd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int TRAILER_BYTES   = vdd_pkg::TRAILER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  input  logic                         first_of_frame,
  input  logic [11:0]                  frame_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         result_kind,
  output logic [7:0]                   stream_tag,
  output logic [63:0]                  span_offset,
  output logic [63:0]                  span_length,
  output logic                         in_range,
  output logic [63:0]                  frame_bytes,
  output logic [1:0]                   frame_status,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vdd_pkg::REGION_W-1:0] region_size
);

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int AW    = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam int CW    = vdd_pkg::CMP_W;
  // floor(sid * SID_RECIP / 2^16) is the exact quotient for any 8-bit sid
  localparam int SID_RECIP = (65536 + STREAM_COUNT - 1) / STREAM_COUNT;

  // ---------------- configuration ----------------
  logic [vdd_pkg::REGION_W-1:0] region;

  assign cfg_ready = 1'b1;

  // ---------------- parse stage state ----------------
  logic [LEN_W-1:0]      byte_pos;
  logic [LEN_W-1:0]      cur_len;
  logic [63:0]           acc;
  logic [6:0]            shift;
  vdd_pkg::phase_t       phase;
  logic [7:0]            cur_sid;
  logic [AW-1:0]         cur_addr;
  logic [63:0]           pend_delta;

  logic [LEN_W-1:0]      byte_pos_next;
  logic [63:0]           acc_next;
  logic [6:0]            shift_next;
  vdd_pkg::phase_t       phase_next;
  logic [7:0]            cur_sid_next;
  logic [AW-1:0]         cur_addr_next;
  logic [63:0]           pend_delta_next;

  logic [CW-1:0]         fl;
  logic [CW-1:0]         flc;
  logic [LEN_W-1:0]      len_c;
  logic [LEN_W-1:0]      pos_c;
  logic [63:0]           acc_c;
  logic [6:0]            shift_c;
  vdd_pkg::phase_t       phase_c;
  logic [63:0]           acc_or;
  logic [6:0]            shift_inc;
  logic [23:0]           sid_prod;
  logic [7:0]            sid_quo;
  logic [15:0]           sid_rem;
  logic                  active;
  logic                  parse;
  logic                  ev_sid;
  logic                  ev_len;
  logic                  a_finish;
  logic [1:0]            a_status;
  logic [63:0]           delta_dec;

  logic                  accept;
  logic                  a_go;

  // ---------------- descriptor stage ----------------
  logic                  b_valid;
  logic                  b_sof;
  logic                  b_sid;
  logic                  b_len_ev;
  logic                  b_finish;
  logic [1:0]            b_status;
  logic [7:0]            b_stream;
  logic [AW-1:0]         b_addr;
  logic [63:0]           b_delta;
  logic [63:0]           b_value;
  logic                  b_vbit;
  logic                  b_fwd;
  logic [63:0]           b_fwd_data;

  logic [63:0]           running_offset;
  logic [63:0]           total;

  logic [STREAM_COUNT-1:0] vbits;
  logic [63:0]           ram_rdata;
  logic                  ram_re;
  logic                  b_write;
  logic                  fwd_hit;

  logic [63:0]           region_ext;
  logic [63:0]           base;
  logic [63:0]           stored;
  logic [63:0]           ro_cur;
  logic [63:0]           off;
  logic                  inr;
  logic [63:0]           tot_cur;
  logic [63:0]           tot_add;
  logic [63:0]           tot_new;
  logic [63:0]           ro_new;
  logic                  b_res;
  logic                  out_free;
  logic                  b_adv;

  // ---------------- parse stage logic ----------------
  always_comb begin
    fl = CW'(frame_length);
    if (fl == '0) begin
      flc = CW'(1);
    end else if (fl > CW'(MAX_FRAME_BYTES)) begin
      flc = CW'(MAX_FRAME_BYTES);
    end else begin
      flc = fl;
    end

    len_c   = first_of_frame ? LEN_W'(flc) : cur_len;
    pos_c   = first_of_frame ? '0 : byte_pos;
    acc_c   = first_of_frame ? '0 : acc;
    shift_c = first_of_frame ? '0 : shift;
    phase_c = first_of_frame ? vdd_pkg::PH_SID : phase;

    active = first_of_frame || (byte_pos < cur_len);
    parse  = ((CW'(pos_c) + CW'(TRAILER_BYTES)) < CW'(len_c)) &&
             (phase_c != vdd_pkg::PH_STOP) && (shift_c <= vdd_pkg::SHIFT_LIMIT);

    // bits shifted past bit 63 drop, so a tenth byte lands only its low bit
    acc_or    = acc_c | ({57'b0, data_byte[6:0]} << shift_c);
    shift_inc = shift_c + vdd_pkg::SHIFT_STEP;

    // table entry = sid modulo STREAM_COUNT, by reciprocal multiply
    sid_prod = 24'(acc_or[7:0]) * 24'(SID_RECIP);
    sid_quo  = sid_prod[23:16];
    sid_rem  = 16'(acc_or[7:0]) - 16'(sid_quo) * 16'(STREAM_COUNT);

    acc_next        = acc_c;
    shift_next      = shift_c;
    phase_next      = phase_c;
    cur_sid_next    = first_of_frame ? '0 : cur_sid;
    cur_addr_next   = first_of_frame ? '0 : cur_addr;
    pend_delta_next = pend_delta;
    ev_sid          = 1'b0;
    ev_len          = 1'b0;

    if (parse) begin
      if (!data_byte[7]) begin
        acc_next   = '0;
        shift_next = '0;
        unique case (phase_c)
          vdd_pkg::PH_SID: begin
            cur_sid_next  = acc_or[7:0];
            cur_addr_next = AW'(sid_rem);
            phase_next    = vdd_pkg::PH_DELTA;
            ev_sid        = 1'b1;
          end
          vdd_pkg::PH_DELTA: begin
            pend_delta_next = acc_or;
            phase_next      = vdd_pkg::PH_LEN;
          end
          vdd_pkg::PH_LEN: begin
            ev_len     = 1'b1;
            phase_next = vdd_pkg::PH_DELTA;
          end
          default: begin
            phase_next = phase_c;
          end
        endcase
      end else begin
        acc_next   = acc_or;
        shift_next = shift_inc;
        // an overlong pair varint stops parsing; an overlong id stays in id phase
        if (shift_inc > vdd_pkg::SHIFT_LIMIT && phase_c != vdd_pkg::PH_SID) begin
          phase_next = vdd_pkg::PH_STOP;
        end
      end
    end

    a_finish = (CW'(pos_c) + CW'(1)) == CW'(len_c);
    if (CW'(len_c) < CW'(TRAILER_BYTES)) begin
      a_status = vdd_pkg::ST_SHORT;
    end else if (phase_next == vdd_pkg::PH_SID) begin
      a_status = vdd_pkg::ST_NOID;
    end else begin
      a_status = vdd_pkg::ST_OK;
    end

    delta_dec     = (pend_delta >> 1) ^ {64{pend_delta[0]}};
    byte_pos_next = pos_c + LEN_W'(1);
  end

  // ---------------- handshake ----------------
  assign b_res    = b_len_ev || b_finish;
  assign out_free = !out_valid || !out_stall;
  assign b_adv    = !b_valid || !b_res || out_free;
  assign in_stall = !b_adv;
  assign accept   = in_valid && !in_stall;
  assign a_go     = accept && active;

  // ---------------- offset table ----------------
  assign b_write = b_valid && b_adv && b_finish && (b_status == vdd_pkg::ST_OK);
  assign ram_re  = a_go && ev_sid;
  // a finish writing the entry that a new frame reads in the same cycle
  assign fwd_hit = b_write && (b_addr == cur_addr_next);

  vdd_ram #(
    .WIDTH (64),
    .DEPTH (STREAM_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (b_write),
    .waddr (b_addr),
    .wdata (ro_new),
    .re    (ram_re),
    .raddr (cur_addr_next),
    .rdata (ram_rdata)
  );

  // ---------------- descriptor stage logic ----------------
  always_comb begin
    region_ext = {{(64 - vdd_pkg::REGION_W){1'b0}}, region};
    base       = region_ext >> 1;
    stored     = b_fwd ? b_fwd_data : (b_vbit ? ram_rdata : '0);
    ro_cur     = b_sid ? ((stored != '0) ? stored : base) : running_offset;
    off        = ro_cur + b_delta;
    inr        = (b_value <= region_ext) && (off <= (region_ext - b_value));
    tot_cur    = b_sof ? '0 : total;
    tot_add    = tot_cur + b_value;
    tot_new    = (b_len_ev && inr) ? tot_add : tot_cur;
    ro_new     = b_len_ev ? off : ro_cur;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      region    <= vdd_pkg::REGION_RESET;
      byte_pos  <= '0;
      cur_len   <= '0;
      shift     <= '0;
      phase     <= vdd_pkg::PH_SID;
      b_valid   <= 1'b0;
      vbits     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        region <= region_size;
      end
      if (a_go) begin
        byte_pos <= byte_pos_next;
        cur_len  <= len_c;
        shift    <= shift_next;
        phase    <= phase_next;
      end
      if (b_adv) begin
        b_valid <= a_go;
      end
      if (b_write) begin
        vbits[b_addr] <= 1'b1;
      end
      if (b_valid && b_res && b_adv) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (a_go) begin
      acc        <= acc_next;
      cur_sid    <= cur_sid_next;
      cur_addr   <= cur_addr_next;
      pend_delta <= pend_delta_next;
    end
    if (b_adv && a_go) begin
      b_sof      <= first_of_frame;
      b_sid      <= ev_sid;
      b_len_ev   <= ev_len;
      b_finish   <= a_finish;
      b_status   <= a_status;
      b_stream   <= cur_sid_next;
      b_addr     <= cur_addr_next;
      b_delta    <= delta_dec;
      b_value    <= acc_or;
      b_vbit     <= vbits[cur_addr_next];
      b_fwd      <= fwd_hit;
      b_fwd_data <= ro_new;
    end
    if (b_valid && b_adv) begin
      running_offset <= ro_new;
      total          <= tot_new;
    end
    if (b_valid && b_res && b_adv) begin
      if (b_finish) begin
        result_kind  <= vdd_pkg::KIND_FINISH;
        stream_tag   <= (b_status == vdd_pkg::ST_OK) ? b_stream : '0;
        span_offset  <= (b_status == vdd_pkg::ST_OK) ? ro_new : '0;
        span_length  <= '0;
        in_range     <= 1'b0;
        frame_bytes  <= (b_status == vdd_pkg::ST_OK) ? tot_new : '0;
        frame_status <= b_status;
        last         <= 1'b1;
      end else begin
        result_kind  <= vdd_pkg::KIND_DESC;
        stream_tag   <= b_stream;
        span_offset  <= off;
        span_length  <= b_value;
        in_range     <= inr;
        frame_bytes  <= '0;
        frame_status <= vdd_pkg::ST_OK;
        last         <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/vdd_checker.sv =====
// ----------------------------------------------------------------------------
// vdd_checker
// Port-level checks on the result channel of the descriptor decoder.
// ----------------------------------------------------------------------------
module vdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        result_kind,
  input logic [7:0]  stream_tag,
  input logic [63:0] frame_bytes,
  input logic [63:0] span_length,
  input logic        in_range,
  input logic [1:0]  frame_status,
  input logic        last
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (result_kind == vdd_pkg::KIND_FINISH)))
    else $error("last does not match result kind");

  // skipped frames report no stream and no bytes
  a_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && frame_status != vdd_pkg::ST_OK |->
      stream_tag == 8'd0 && frame_bytes == 64'd0)
    else $error("skipped frame carries stream data");

  a_desc: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> frame_status == vdd_pkg::ST_OK && frame_bytes == 64'd0)
    else $error("descriptor carries frame fields");

  a_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> span_length == 64'd0 && !in_range)
    else $error("finish carries descriptor fields");

endmodule

bind varint_delta_descriptor_decoder vdd_checker u_vdd_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the varint delta descriptor decoder. Frames of
// LEB128 stream ids and zigzag delta / length pairs are built at random,
// mostly well formed, with truncated, overlong, abandoned and stray input
// mixed in. A scoreboard predicts every descriptor and frame finish,
// including the per-stream offset table, and checks results in order while
// both channels idle and stall at random and the region size is rewritten
// between segments.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_FRAME = vdd_pkg::MAX_FRAME_BYTES_DEF;
  localparam int TRAILER   = vdd_pkg::TRAILER_BYTES_DEF;

  typedef struct packed {
    logic        kind;
    logic [7:0]  sid;
    logic [63:0] offset;
    logic [63:0] length;
    logic        inr;
    logic [63:0] total;
    logic [1:0]  status;
    logic        fin;
  } span_rec_t;

  class descriptor_scoreboard;
    logic [vdd_pkg::REGION_W-1:0] region;
    logic [63:0] offset_table [256];
    int unsigned byte_pos;
    int unsigned frame_len;
    logic [63:0] acc;
    int unsigned shift;
    vdd_pkg::phase_t phase;
    logic [7:0]  sid;
    logic [63:0] delta_code;
    logic [63:0] run_off;
    logic [63:0] in_range_total;
    span_rec_t   spans_due [$];
    int          mismatches;
    int          descs_seen;
    int          finishes_seen;

    function new();
      region = vdd_pkg::REGION_RESET;
      foreach (offset_table[i]) offset_table[i] = 64'd0;
      frame_len = 0;
      start_frame();
      mismatches = 0;
      descs_seen = 0;
      finishes_seen = 0;
    endfunction

    function void start_frame();
      byte_pos = 0;
      acc = 64'd0;
      shift = 0;
      phase = vdd_pkg::PH_SID;
      sid = 8'd0;
      delta_code = 64'd0;
      run_off = 64'd0;
      in_range_total = 64'd0;
    endfunction

    function int pending();
      return spans_due.size();
    endfunction

    // one accepted byte; queues the result it causes, if any
    function void note_byte(logic [7:0] b, logic sof, logic [11:0] fl);
      span_rec_t   r;
      logic [63:0] v;
      logic [63:0] reg64;
      bit          emit;
      if (sof) begin
        frame_len = (fl == 0) ? 1 : ((fl > MAX_FRAME) ? MAX_FRAME : fl);
        start_frame();
      end else if (byte_pos >= frame_len) begin
        return;
      end
      emit = 0;
      reg64 = 64'(region);
      if (frame_len >= TRAILER && byte_pos < frame_len - TRAILER &&
          phase != vdd_pkg::PH_STOP && shift <= vdd_pkg::SHIFT_LIMIT) begin
        acc |= 64'(b[6:0]) << shift;
        if (!b[7]) begin
          v = acc;
          acc = 64'd0;
          shift = 0;
          case (phase)
            vdd_pkg::PH_SID: begin
              sid = v[7:0];
              run_off = (offset_table[sid] != 0) ? offset_table[sid] : reg64 >> 1;
              phase = vdd_pkg::PH_DELTA;
            end
            vdd_pkg::PH_DELTA: begin
              delta_code = v;
              phase = vdd_pkg::PH_LEN;
            end
            default: begin
              run_off = run_off + ((delta_code >> 1) ^ {64{delta_code[0]}});
              r = span_rec_t'{vdd_pkg::KIND_DESC, sid, run_off, v,
                              (v <= reg64) && (run_off <= reg64 - v), 64'd0,
                              vdd_pkg::ST_OK, 1'b0};
              if (r.inr) in_range_total += v;
              emit = 1;
              phase = vdd_pkg::PH_DELTA;
            end
          endcase
        end else begin
          shift += vdd_pkg::SHIFT_STEP;
          if (shift > vdd_pkg::SHIFT_LIMIT && phase != vdd_pkg::PH_SID)
            phase = vdd_pkg::PH_STOP;
        end
      end
      if (byte_pos + 1 == frame_len) begin
        if (frame_len < TRAILER) begin
          r = span_rec_t'{vdd_pkg::KIND_FINISH, 8'd0, 64'd0, 64'd0, 1'b0, 64'd0,
                          vdd_pkg::ST_SHORT, 1'b1};
        end else if (phase == vdd_pkg::PH_SID) begin
          r = span_rec_t'{vdd_pkg::KIND_FINISH, 8'd0, 64'd0, 64'd0, 1'b0, 64'd0,
                          vdd_pkg::ST_NOID, 1'b1};
        end else begin
          offset_table[sid] = run_off;
          r = span_rec_t'{vdd_pkg::KIND_FINISH, sid, run_off, 64'd0, 1'b0, in_range_total,
                          vdd_pkg::ST_OK, 1'b1};
        end
        emit = 1;
      end
      byte_pos++;
      if (emit) spans_due.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task check_result(span_rec_t got);
      span_rec_t   want;
      logic [63:0] g [8];
      logic [63:0] w [8];
      string       names [8];
      if (spans_due.size() == 0) begin
        report($sformatf("result with nothing expected, kind %0d stream %0d",
                         got.kind, got.sid));
        return;
      end
      want = spans_due.pop_front();
      if (want.kind == vdd_pkg::KIND_DESC) descs_seen++;
      else finishes_seen++;
      names = '{"result_kind", "stream_tag", "span_offset", "span_length",
                "in_range", "frame_bytes", "frame_status", "last"};
      g = '{64'(got.kind), 64'(got.sid), got.offset, got.length, 64'(got.inr),
            got.total, 64'(got.status), 64'(got.fin)};
      w = '{64'(want.kind), 64'(want.sid), want.offset, want.length, 64'(want.inr),
            want.total, 64'(want.status), 64'(want.fin)};
      foreach (g[i]) begin
        if (g[i] !== w[i])
          report($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                           descs_seen + finishes_seen, names[i], g[i], w[i]));
      end
    endtask
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [7:0]                   data_byte;
  logic                         first_of_frame;
  logic [11:0]                  frame_length;
  logic                         out_valid;
  logic                         out_stall;
  logic                         result_kind;
  logic [7:0]                   stream_tag;
  logic [63:0]                  span_offset;
  logic [63:0]                  span_length;
  logic                         in_range;
  logic [63:0]                  frame_bytes;
  logic [1:0]                   frame_status;
  logic                         last;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [vdd_pkg::REGION_W-1:0] region_size;

  descriptor_scoreboard desc_sb = new();
  logic [7:0] body [$];
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int items_sent = 0;
  int frames_sent = 0;

  varint_delta_descriptor_decoder i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      desc_sb.check_result(span_rec_t'{result_kind, stream_tag, span_offset, span_length,
                                       in_range, frame_bytes, frame_status, last});
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [63:0] rand_bits(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (w <= 0) return 64'd0;
    if (w < 64) v &= (64'd1 << w) - 64'd1;
    return v;
  endfunction

  function automatic logic [63:0] rand_len();
    return rand_bits(($urandom_range(0, 7) == 0) ? $urandom_range(0, 64)
                                                 : $urandom_range(0, 20));
  endfunction

  // extra continuation bytes give a non-minimal encoding
  function automatic int pick_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [vdd_pkg::REGION_W-1:0] pick_region(int seg);
    logic [63:0] v;
    case (seg)
      0: v = 64'd1;
      1: v = 64'd1 << 48;
      2: v = rand_bits($urandom_range(1, 49));
      default: v = rand_bits($urandom_range(1, 20));
    endcase
    if (v == 0) v = 64'd1;
    if (v > (64'd1 << 48)) v = 64'd1 << 48;
    return v[vdd_pkg::REGION_W-1:0];
  endfunction

  // junk in the upper bits of a tenth byte must be dropped by the block
  task automatic put_varint(input logic [63:0] v, input int pad, input bit junk_top);
    int          n;
    int          total;
    logic [6:0]  chunk;
    logic [63:0] rest;
    n = 1;
    rest = v >> 7;
    while (rest != 0 && n < 10) begin
      n++;
      rest = rest >> 7;
    end
    total = (n + pad > 10) ? 10 : n + pad;
    for (int i = 0; i < total; i++) begin
      chunk = 7'(v >> (7 * i));
      if (i == 9 && junk_top) chunk[6:1] = 6'($urandom);
      body.push_back({i < total - 1, chunk});
    end
  endtask

  task automatic put_overlong();
    int n;
    n = $urandom_range(10, 12);
    for (int i = 0; i < n; i++) body.push_back({1'b1, 7'($urandom)});
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sof, input logic [11:0] fl);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    first_of_frame <= sof;
    frame_length <= fl;
    do @(posedge clk); while (in_stall);
    desc_sb.note_byte(b, sof, fl);
    items_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic write_region(input logic [vdd_pkg::REGION_W-1:0] v);
    cfg_valid <= 1'b1;
    region_size <= v;
    do @(posedge clk); while (!cfg_ready);
    desc_sb.region = v;
    cfg_valid <= 1'b0;
  endtask

  // wait for all expected results, then let bytes still in flight drain
  task automatic settle();
    int waited;
    waited = 0;
    while (desc_sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic run_frame();
    logic [63:0] sid_v;
    logic [63:0] cur;
    logic [63:0] d;
    logic [63:0] ln;
    logic [63:0] reg64;
    logic [7:0]  b;
    int          npairs;
    int          brk;
    int          flen_field;
    int          n_send;
    body.delete();
    reg64 = 64'(desc_sb.region);
    case ($urandom_range(0, 9))
      0: sid_v = rand_bits($urandom_range(9, 64));
      1: sid_v = 64'd255;
      default: sid_v = 64'($urandom_range(0, 5));
    endcase
    if ($urandom_range(0, 29) == 0) put_overlong();
    else put_varint(sid_v, pick_pad(), $urandom_range(0, 1));
    // track the offset the frame will run at, to aim deltas at zero and the region edge
    cur = desc_sb.offset_table[sid_v[7:0]];
    if (cur == 0) cur = reg64 >> 1;
    npairs = $urandom_range(0, 6);
    brk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, npairs) : -1;
    for (int p = 0; p < npairs && body.size() < 2030; p++) begin
      if (p == brk) put_overlong();
      ln = rand_len();
      case ($urandom_range(0, 9))
        0: d = -cur;
        1: d = reg64 - ln - cur;
        2: d = reg64 - ln - cur + 64'd1;
        3: d = rand_bits(64);
        default: begin
          d = rand_bits($urandom_range(0, 24));
          if ($urandom_range(0, 1)) d = -d;
        end
      endcase
      cur += d;
      put_varint({d[62:0], 1'b0} ^ {64{d[63]}}, pick_pad(), $urandom_range(0, 1));
      put_varint(ln, pick_pad(), $urandom_range(0, 1));
    end
    if (brk == npairs) put_overlong();
    // delta with no length
    if ($urandom_range(0, 9) == 0) put_varint(rand_bits(64), 0, 1'b0);
    flen_field = body.size() + TRAILER;
    case ($urandom_range(0, 11))
      0: flen_field = $urandom_range(0, flen_field);
      1: flen_field += $urandom_range(1, 6);
      default: ;
    endcase
    n_send = (flen_field == 0) ? 1 : ((flen_field > MAX_FRAME) ? MAX_FRAME : flen_field);
    if (n_send > 1 && $urandom_range(0, 24) == 0)
      n_send = $urandom_range(1, n_send - 1);
    for (int i = 0; i < n_send; i++) begin
      if (i < body.size()) b = body[i];
      else b = 8'($urandom);
      send_byte(b, i == 0, (i == 0) ? 12'(flen_field) : 12'($urandom));
    end
    frames_sent++;
    if ($urandom_range(0, 24) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 12'($urandom));
  endtask

  task automatic directed_frames();
    logic [7:0] b;
    send_byte(8'hFF, 1'b0, 12'hFFF);   // no frame open yet: dropped
    send_byte(8'h00, 1'b1, 12'h000);   // zero length runs as a one-byte short frame
    send_byte(8'hA5, 1'b1, 12'hFFF);   // abandoned by the next start of frame
    // stream 255 in two bytes, ten-byte delta with junk above bit 63, zero length
    body.delete();
    body.push_back(8'hFF);
    body.push_back(8'h01);
    repeat (9) body.push_back(8'hFF);
    body.push_back(8'h7F);
    body.push_back(8'h00);
    for (int i = 0; i < 13 + TRAILER; i++) begin
      if (i < body.size()) b = body[i];
      else b = 8'($urandom);
      send_byte(b, i == 0, (i == 0) ? 12'(13 + TRAILER) : 12'($urandom));
    end
    frames_sent += 3;
  endtask

  initial begin
    int target;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'd0;
    first_of_frame <= 1'b0;
    frame_length <= 12'd0;
    cfg_valid <= 1'b0;
    region_size <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed_frames();
    idle_input();
    settle();

    for (int mix = 0; mix < 3; mix++) begin
      src_idle_pct = (mix == 0) ? 38 : ((mix == 1) ? 45 : 0);
      sink_stall_pct = (mix == 0) ? 45 : ((mix == 1) ? 38 : 0);
      for (int seg = 0; seg < 4; seg++) begin
        write_region(pick_region(seg));
        target = 1950 * (mix * 4 + seg + 1) / 12;
        while (items_sent < target) run_frame();
        idle_input();
        settle();
      end
    end

    if (desc_sb.pending() != 0)
      desc_sb.report($sformatf("%0d expected results never arrived", desc_sb.pending()));
    $display("summary: %0d bytes in %0d frames, %0d descriptors and %0d finishes checked",
             items_sent, frames_sent, desc_sb.descs_seen, desc_sb.finishes_seen);
    $display("summary: region sizes 1 to 2^48, three idle/stall mixes, %0d mismatches",
             desc_sb.mismatches);
    if (desc_sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vdd_pkg.sv
rtl/vdd_ram.sv
rtl/varint_delta_descriptor_decoder.sv
rtl/vdd_checker.sv
tb/tb.sv
